FILE: sv/tli_pkg.sv
// Shared widths, operation codes and status codes for the time interval locator.
`default_nettype none
package tli_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int TIME_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 8;
  localparam int FRAC_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 32'h7FFF_FFFF;
  localparam logic [FRAC_W-1:0] FRAC_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

FILE: sv/tli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tli_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/time_interval_locator.sv
// Time interval locator: stamp table with linear interval search and serial fraction divide.
//
// Each request is taken only while the block is idle. Append, clear and unused codes, and
// queries on fewer than two stamps, go straight to the done state. A query on a table of
// N >= 2 stamps walks the table over the single RAM read port, one stamp per cycle, and
// stops at the first stamp after the query time; when an interval whose end stamp exceeds
// its start is found, a restoring divider then produces one quotient bit per cycle over
// TIME_BITS+FRAC_BITS steps, and a fix step negates or saturates the fraction. The result
// waits in an output register, so the next request is taken while it is still stalled.
`default_nettype none
module time_interval_locator #(
  parameter int DEPTH     = tli_pkg::DEPTH_DEF,
  parameter int TIME_BITS = tli_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = tli_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [tli_pkg::OP_W-1:0]     operation,
  input  wire logic [TIME_BITS-1:0]         stamp,
  input  wire logic [TIME_BITS-1:0]         query_time,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tli_pkg::INDEX_W-1:0]  interval_index,
  output logic      [tli_pkg::FRAC_W-1:0]   fraction,
  output logic      [tli_pkg::STATUS_W-1:0] status
);

  import tli_pkg::*;

  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int DIV_STEPS = TIME_BITS + FRAC_BITS;
  localparam int DCW       = $clog2(DIV_STEPS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [CW-1:0]        count;
  logic [TIME_BITS-1:0] qtime;
  logic [AW-1:0]        walk_addr;
  logic                 rd_pend;
  logic [AW-1:0]        rd_idx;
  logic [TIME_BITS-1:0] prev;
  logic [TIME_BITS-1:0] divisor;
  logic [DIV_STEPS-1:0] dvd;
  logic [TIME_BITS-1:0] rem;
  logic [FRAC_W-1:0]    quo;
  logic                 ovf;
  logic                 neg;
  logic [DCW-1:0]       div_cnt;

  logic [INDEX_W-1:0]   res_index;
  logic [FRAC_W-1:0]    res_frac;
  logic [STATUS_W-1:0]  res_status;

  logic                 accept;
  logic                 ram_we;
  logic [TIME_BITS-1:0] rdata;
  logic                 found;
  logic                 at_last;
  logic [TIME_BITS:0]   rr;
  logic [TIME_BITS:0]   diff;
  logic                 ge;
  logic                 sat_pos;
  logic                 sat_neg;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (operation == OP_APPEND) && (count < CW'(DEPTH));

  tli_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (stamp),
    .raddr (walk_addr),
    .rdata (rdata)
  );

  assign found   = rd_pend && (rd_idx != '0) && (rdata > qtime);
  assign at_last = (CW'(rd_idx) == count - CW'(1));

  assign rr   = {rem, dvd[DIV_STEPS-1]};
  assign diff = rr - {1'b0, divisor};
  assign ge   = (rr >= {1'b0, divisor});

  assign sat_pos = ovf || quo[FRAC_W-1];
  assign sat_neg = ovf || (quo[FRAC_W-1] && (quo[FRAC_W-2:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_index  <= '0;
            res_frac   <= '0;
            res_status <= ST_OK;
            qtime      <= query_time;
            walk_addr  <= '0;
            rd_pend    <= 1'b0;
            state      <= S_DONE;
            case (operation)
              OP_APPEND: begin
                if (count < CW'(DEPTH)) begin
                  res_index <= INDEX_W'(count);
                  count     <= count + CW'(1);
                end else begin
                  res_index  <= INDEX_W'(DEPTH - 1);
                  res_status <= ST_FULL;
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                end else if (count != CW'(1)) begin
                  state <= S_WALK;
                end
              end
              OP_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          rd_pend   <= 1'b1;
          rd_idx    <= walk_addr;
          walk_addr <= walk_addr + AW'(1);
          if (rd_pend) begin
            prev <= rdata;
            if (found) begin
              rd_pend   <= 1'b0;
              res_index <= INDEX_W'(rd_idx - AW'(1));
              if (rdata > prev) begin
                divisor <= rdata - prev;
                neg     <= (qtime < prev);
                dvd     <= {((qtime >= prev) ? (qtime - prev) : (prev - qtime)),
                            {FRAC_BITS{1'b0}}};
                rem     <= '0;
                quo     <= '0;
                ovf     <= 1'b0;
                div_cnt <= DCW'(DIV_STEPS);
                state   <= S_DIV;
              end else begin
                state <= S_DONE;
              end
            end else if (rd_idx != '0 && at_last) begin
              rd_pend    <= 1'b0;
              res_index  <= INDEX_W'(rd_idx);
              res_status <= ST_PAST_END;
              state      <= S_DONE;
            end
          end
        end
        S_DIV: begin
          rem     <= ge ? diff[TIME_BITS-1:0] : rr[TIME_BITS-1:0];
          dvd     <= dvd << 1;
          ovf     <= ovf | quo[FRAC_W-1];
          quo     <= {quo[FRAC_W-2:0], ge};
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == DCW'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (neg) begin
            res_frac   <= sat_neg ? FRAC_MIN : (FRAC_W'(0) - quo);
            res_status <= sat_neg ? ST_SAT : ST_OK;
          end else begin
            res_frac   <= sat_pos ? FRAC_MAX : quo;
            res_status <= sat_pos ? ST_SAT : ST_OK;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            interval_index <= res_index;
            fraction       <= res_frac;
            status         <= res_status;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_walk_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && rd_pend |-> CW'(rd_idx) < count)
    else $error("table walk read beyond filled entries");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SAT) |-> (fraction == FRAC_MAX) || (fraction == FRAC_MIN))
    else $error("saturated status without saturated fraction");

  a_past_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_PAST_END) || (status == ST_EMPTY)) |-> fraction == '0)
    else $error("nonzero fraction on past-end or empty result");
`endif

endmodule
`default_nettype wire
